// File: design/seta_pkg.sv
// Shared types and constants for the scope edge trigger with auto holdoff.
// Holds request codes, register indexes, the config struct and the stage struct.
// Used by every module of the block; no dependencies of its own.
package seta_pkg;

  localparam int SAMPLE_BITS_DEF = 16;
  localparam int COUNT_BITS_DEF  = 24;

  localparam int LEVEL_BITS   = 16;
  localparam int HYST_BITS    = 15;
  localparam int TIMEOUT_BITS = 24;
  localparam int HOLD_BITS    = 21;
  localparam int CFG_DATA_BITS = 24;
  localparam int CFG_IDX_BITS  = 3;

  localparam logic [LEVEL_BITS-1:0]   LEVEL_RST   = 16'd0;
  localparam logic [HYST_BITS-1:0]    HYST_RST    = 15'd256;
  localparam logic [TIMEOUT_BITS-1:0] TIMEOUT_RST = 24'd1000000;
  localparam logic [HOLD_BITS-1:0]    WINDOW_RST  = 21'd32768;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_LEVEL   = 3'd0,
    CFG_HYST    = 3'd1,
    CFG_EDGE    = 3'd2,
    CFG_AUTO    = 3'd3,
    CFG_TIMEOUT = 3'd4,
    CFG_WINDOW  = 3'd5,
    CFG_SINGLE  = 3'd6
  } cfg_idx_t;

  localparam logic [1:0] MODE_SAMPLE = 2'd0;
  localparam logic [1:0] MODE_ARM    = 2'd1;
  localparam logic [1:0] MODE_STOP   = 2'd2;

  localparam logic [1:0] EDGE_RISE = 2'd0;
  localparam logic [1:0] EDGE_FALL = 2'd1;
  localparam logic [1:0] EDGE_BOTH = 2'd2;

  localparam logic [1:0] FIRE_NONE = 2'd0;
  localparam logic [1:0] FIRE_EDGE = 2'd1;
  localparam logic [1:0] FIRE_AUTO = 2'd2;

  typedef enum logic [1:0] {
    LVL_LOW  = 2'd0,
    LVL_HIGH = 2'd1,
    LVL_INIT = 2'd2
  } lvl_state_t;

  typedef struct packed {
    logic [LEVEL_BITS-1:0]   level;
    logic [HYST_BITS-1:0]    hyst;
    logic [1:0]              edge_sel;
    logic                    auto_en;
    logic [TIMEOUT_BITS-1:0] timeout;
    logic [HOLD_BITS-1:0]    window;
    logic                    single;
  } seta_cfg_t;

  // One request after the input register: threshold compares already resolved.
  typedef struct packed {
    logic       valid;
    logic [1:0] mode;
    logic       below;
    logic       above;
  } seta_item_t;

endpackage

// File: design/scope_edge_trigger_auto_holdoff_top.sv
// Top level of the scope edge trigger: configuration registers, input stage
// and trigger core. Depends on seta_pkg, seta_front and seta_core.
//
//  channel | direction | handshake          | payload
//  in_     | request   | in_valid/in_stall   | in_mode, in_sample
//  out_    | result    | out_valid/out_stall | out_fire_event, out_in_holdoff, out_running
//  cfg_    | write     | cfg_we              | cfg_index, cfg_data
//
// One request per clock is accepted unless the result stalls; each gives one result via the
// input and result registers. Level state, holdoff and countdown update together in the core,
// which sets the one-request-per-cycle rate. Reset is synchronous and active low.
// A stalled result holds the core; one more request waits in the input register.
module scope_edge_trigger_auto_holdoff_top import seta_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               in_mode,
  input  logic [SAMPLE_BITS-1:0]   in_sample,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [1:0]               out_fire_event,
  output logic                     out_in_holdoff,
  output logic                     out_running,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  seta_cfg_t  cfg_r;
  seta_item_t item;
  logic       core_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.level    <= LEVEL_RST;
      cfg_r.hyst     <= HYST_RST;
      cfg_r.edge_sel <= EDGE_RISE;
      cfg_r.auto_en  <= 1'b1;
      cfg_r.timeout  <= TIMEOUT_RST;
      cfg_r.window   <= WINDOW_RST;
      cfg_r.single   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LEVEL:   cfg_r.level    <= cfg_data[LEVEL_BITS-1:0];
        CFG_HYST:    cfg_r.hyst     <= cfg_data[HYST_BITS-1:0];
        CFG_EDGE:    cfg_r.edge_sel <= cfg_data[1:0];
        CFG_AUTO:    cfg_r.auto_en  <= cfg_data[0];
        CFG_TIMEOUT: cfg_r.timeout  <= cfg_data[TIMEOUT_BITS-1:0];
        CFG_WINDOW:  cfg_r.window   <= cfg_data[HOLD_BITS-1:0];
        CFG_SINGLE:  cfg_r.single   <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  seta_front #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_mode    (in_mode),
    .in_sample  (in_sample),
    .core_ready (core_ready),
    .item       (item)
  );

  seta_core #(
    .COUNT_BITS(COUNT_BITS)
  ) u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .item           (item),
    .core_ready     (core_ready),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_fire_event (out_fire_event),
    .out_in_holdoff (out_in_holdoff),
    .out_running    (out_running)
  );

endmodule

// File: design/seta_front.sv
// Input stage: takes a request, compares the sample against both thresholds,
// and holds the result for the trigger core. Depends on seta_pkg.
module seta_front import seta_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  seta_cfg_t              cfg,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [1:0]             in_mode,
  input  logic [SAMPLE_BITS-1:0] in_sample,
  input  logic                   core_ready,
  output seta_item_t             item
);

  localparam int CMP_W = ((SAMPLE_BITS > LEVEL_BITS) ? SAMPLE_BITS : LEVEL_BITS) + 2;

  logic signed [SAMPLE_BITS-1:0] lvl_s;
  logic signed [CMP_W-1:0]       lvl_w;
  logic signed [CMP_W-1:0]       hyst_w;
  logic signed [CMP_W-1:0]       hi_w;
  logic signed [CMP_W-1:0]       lo_w;
  logic signed [CMP_W-1:0]       smp_w;
  logic                          accept;
  seta_item_t                    item_r;
  seta_item_t                    item_nxt;

  // The level register is read at the sample width, as the sample is.
  assign lvl_s  = SAMPLE_BITS'(cfg.level);
  assign lvl_w  = CMP_W'(lvl_s);
  assign hyst_w = signed'(CMP_W'(cfg.hyst));
  assign hi_w   = lvl_w + hyst_w;
  assign lo_w   = lvl_w - hyst_w;
  assign smp_w  = CMP_W'(signed'(in_sample));

  assign in_stall = item_r.valid && !core_ready;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    item_nxt = item_r;
    if (accept) begin
      item_nxt.valid = 1'b1;
      item_nxt.mode  = in_mode;
      item_nxt.below = (smp_w < lo_w);
      item_nxt.above = (smp_w > hi_w);
    end else if (core_ready) begin
      item_nxt.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_r.valid <= 1'b0;
    end else begin
      item_r.valid <= item_nxt.valid;
    end
    item_r.mode  <= item_nxt.mode;
    item_r.below <= item_nxt.below;
    item_r.above <= item_nxt.above;
  end

  assign item = item_r;

endmodule

// File: design/seta_core.sv
// Trigger core: level state, holdoff and auto countdown, and the result register.
// Takes compare results from seta_front. Depends on seta_pkg.
module seta_core import seta_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  seta_cfg_t  cfg,
  input  seta_item_t item,
  output logic       core_ready,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_fire_event,
  output logic       out_in_holdoff,
  output logic       out_running
);

  localparam logic [COUNT_BITS-1:0] CD_RST = COUNT_BITS'(TIMEOUT_RST);

  lvl_state_t            lvl_r, lvl_nxt;
  logic [COUNT_BITS-1:0] cd_r, cd_nxt, cd_pre;
  logic [HOLD_BITS-1:0]  hold_r, hold_nxt;
  logic                  run_r, run_nxt;
  logic                  oval_r, oval_nxt;
  logic [1:0]            fire_r, fire_nxt;
  logic                  held_r, held_nxt;
  logic                  take;
  logic                  rise_ok, fall_ok, edge_hit, auto_hit;
  lvl_state_t            lvl_cmp;

  assign core_ready = !oval_r || !out_stall;
  assign take       = item.valid && core_ready;

  assign rise_ok  = (cfg.edge_sel == EDGE_RISE) || (cfg.edge_sel == EDGE_BOTH);
  assign fall_ok  = (cfg.edge_sel == EDGE_FALL) || (cfg.edge_sel == EDGE_BOTH);
  assign edge_hit = (item.below && lvl_r == LVL_HIGH && fall_ok) ||
                    (item.above && lvl_r == LVL_LOW && rise_ok);

  // Without auto or in single mode, the countdown is pinned to the window before the fire test,
  // so a zero window still fires an auto trigger unless single mode is on.
  assign cd_pre   = (!cfg.auto_en || cfg.single) ? COUNT_BITS'(cfg.window) : cd_r;
  assign auto_hit = (cd_pre == '0) && !cfg.single;

  always_comb begin
    if (item.below) begin
      lvl_cmp = LVL_LOW;
    end else if (item.above) begin
      lvl_cmp = LVL_HIGH;
    end else begin
      lvl_cmp = lvl_r;
    end
  end

  always_comb begin
    lvl_nxt  = lvl_r;
    cd_nxt   = cd_r;
    hold_nxt = hold_r;
    run_nxt  = run_r;
    fire_nxt = FIRE_NONE;
    held_nxt = 1'b0;
    if (take) begin
      case (item.mode)
        MODE_ARM: begin
          run_nxt  = 1'b1;
          lvl_nxt  = LVL_INIT;
          hold_nxt = '0;
        end
        MODE_STOP: begin
          run_nxt = 1'b0;
        end
        MODE_SAMPLE: begin
          if (run_r) begin
            if (hold_r != '0) begin
              hold_nxt = hold_r - 1'b1;
              held_nxt = 1'b1;
            end else if (edge_hit || auto_hit) begin
              hold_nxt = cfg.window;
              lvl_nxt  = LVL_INIT;
              if (edge_hit) begin
                fire_nxt = FIRE_EDGE;
                cd_nxt   = COUNT_BITS'(cfg.timeout);
                if (cfg.single) begin
                  run_nxt = 1'b0;
                end
              end else begin
                fire_nxt = FIRE_AUTO;
                cd_nxt   = COUNT_BITS'(cfg.window);
              end
            end else begin
              lvl_nxt = lvl_cmp;
              cd_nxt  = (cd_pre != '0) ? cd_pre - 1'b1 : cd_pre;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (take) begin
      oval_nxt = 1'b1;
    end else if (out_stall) begin
      oval_nxt = oval_r;
    end else begin
      oval_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lvl_r  <= LVL_INIT;
      cd_r   <= CD_RST;
      hold_r <= '0;
      run_r  <= 1'b1;
      oval_r <= 1'b0;
    end else begin
      lvl_r  <= lvl_nxt;
      cd_r   <= cd_nxt;
      hold_r <= hold_nxt;
      run_r  <= run_nxt;
      oval_r <= oval_nxt;
    end
    if (take) begin
      fire_r <= fire_nxt;
      held_r <= held_nxt;
    end
  end

  assign out_valid      = oval_r;
  assign out_fire_event = fire_r;
  assign out_in_holdoff = held_r;
  // The running flag moves only with a request taken, so it is the post-step value.
  assign out_running    = run_r;

endmodule

// File: design/seta_checker.sv
// Port-level checks for the scope edge trigger, bound to the top level.
// Depends on seta_pkg and scope_edge_trigger_auto_holdoff_top.
module seta_checker import seta_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] out_fire_event,
  input logic       out_in_holdoff,
  input logic       out_running
);

  // A result waiting on a stall stays put.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_fire_event) &&
      $stable(out_in_holdoff) && $stable(out_running))
    else $error("stalled result changed");

  // A skipped sample never fires.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_in_holdoff |-> out_fire_event == FIRE_NONE)
    else $error("fire reported on a held-off sample");

  // Holdoff only counts down while acquisition runs.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_in_holdoff |-> out_running)
    else $error("holdoff reported while stopped");

  // Auto fire is blocked in single mode, so it never stops the block.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_fire_event == FIRE_AUTO |-> out_running)
    else $error("auto fire left the block stopped");

endmodule

bind scope_edge_trigger_auto_holdoff_top seta_checker u_seta_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_fire_event (out_fire_event),
  .out_in_holdoff (out_in_holdoff),
  .out_running    (out_running)
);
